### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define CHK_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/mlp3_pkg.sv
// Package with shared types, codes and arithmetic helpers of the perceptron unit.
package mlp3_pkg;

    // Request codes of the input channel.
    localparam logic REQ_PARAM   = 1'b0;
    localparam logic REQ_FEATURE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IN_DIM  = 2'd0;
    localparam logic [1:0] CFG_HIDDEN1 = 2'd1;
    localparam logic [1:0] CFG_HIDDEN2 = 2'd2;
    localparam logic [1:0] CFG_OUT_DIM = 2'd3;

    // One in Q4.12, used to scale a bias into the Q24.24 accumulator.
    localparam logic signed [15:0] Q_ONE = 16'sd4096;

    // Control flags that travel with each MAC operation down the pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic bias;
        logic oob;
    } mac_flags_t;

    // Round a Q24.24 sum to Q4.12 (half up) and saturate to 16 bits.
    function automatic logic signed [15:0] round_sat(input logic signed [47:0] acc);
        logic signed [47:0] v;
        logic signed [35:0] q;
        begin
            v = acc + 48'sd2048;
            q = 36'(v >>> 12);
            if (q > 36'sd32767) begin
                round_sat = 16'sh7FFF;
            end else if (q < -36'sd32768) begin
                round_sat = 16'sh8000;
            end else begin
                round_sat = q[15:0];
            end
        end
    endfunction

endpackage

### rtl/mlp3_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mlp3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/mlp_three_layer_inference_unit.sv
// Top level of the three-layer perceptron inference unit.
//
// Usage: the s_ channel carries requests. A request with s_req_type = 0 writes
// s_value into the parameter store at s_param_index (writes past the store are
// dropped). A request with s_req_type = 1 appends a Q4.12 feature; the feature
// that completes the vector of in_dim entries starts the network. The m_
// channel then returns out_dim Q4.12 results, with m_out_index counting up and
// m_last on the final one. The cfg_ channel writes the four size registers and
// is taken only while the unit is idle.
// Datapath: a parameter write or a non-final feature is taken while idle. The final
// feature starts the setup states; then in each layer every neuron issues one MAC
// for its bias and one per input, the pipeline drains and the next layer loads
// between layers, and it drains after each output neuron. During issue a single
// multiplier runs one MAC per cycle, fed by the parameter memory read port, except
// while an output neuron waits for a free output slot.
// Reset clears the feature count, restores sizes 64/64/64/16 and empties the
// pipeline; stored parameters keep undefined contents until written. A stalled
// receiver holds the output register and holds off the next output neuron;
// s_ready stays low until the vector is finished.
`include "assert_macros.svh"

module mlp_three_layer_inference_unit
    import mlp3_pkg::*;
#(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_HIDDEN  = 64,
    parameter int MAX_OUTPUTS = 16,
    parameter int PARAM_DEPTH = 16384
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [13:0]        s_param_index,
    input  logic signed [15:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_value,
    output logic [3:0]         m_out_index,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);
    localparam int CW  = $clog2(MAX_INPUTS + MAX_HIDDEN + MAX_OUTPUTS + 1);
    localparam int FCW = $clog2(MAX_INPUTS + 1);
    localparam int MAX_SPAN = MAX_HIDDEN * MAX_INPUTS + MAX_HIDDEN * MAX_HIDDEN
                            + MAX_OUTPUTS * MAX_HIDDEN + 2 * MAX_HIDDEN + MAX_OUTPUTS;
    localparam int SPW = $clog2(MAX_SPAN + 1);
    localparam int RAW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
    localparam int ACT_DEPTH = MAX_INPUTS + 2 * MAX_HIDDEN;
    localparam int AAW = $clog2(ACT_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP1, ST_SETUP2, ST_LOAD, ST_ISSUE, ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        LAYER_1, LAYER_2, LAYER_3
    } layer_t;

    // Configuration registers.
    logic [6:0] in_dim_reg, hidden1_reg, hidden2_reg;
    logic [4:0] out_dim_reg;

    // Sequencer state.
    state_t         state_reg;
    layer_t         layer_reg;
    logic [FCW-1:0] count_reg;
    logic [SPW-1:0] p1_reg, p2_reg, p3_reg;
    logic [SPW-1:0] ob1_reg, ow2_reg, ob2_reg, ow3_reg, ob3_reg;
    logic [SPW-1:0] w_ptr_reg, bias_ptr_reg;
    logic [CW-1:0]  nsrc_reg, ndst_reg, e_reg, j_reg, rj_reg;
    logic [AAW-1:0] src_base_reg;

    // MAC pipeline.
    mac_flags_t         f1_reg, f2_reg, f0;
    logic signed [31:0] prod_reg;
    logic signed [47:0] acc_reg;
    logic               done_reg;

    // Output register.
    logic               m_valid_reg, m_last_reg;
    logic signed [15:0] m_out_value_reg;
    logic [3:0]         m_out_index_reg;

    // Effective sizes after clamping to the supported range.
    logic [CW-1:0] ni, n1, n2, no;

    always_comb begin
        ni = (in_dim_reg == 7'd0) ? CW'(1) :
             (32'(in_dim_reg) > MAX_INPUTS) ? CW'(MAX_INPUTS) : CW'(in_dim_reg);
        n1 = (hidden1_reg == 7'd0) ? CW'(1) :
             (32'(hidden1_reg) > MAX_HIDDEN) ? CW'(MAX_HIDDEN) : CW'(hidden1_reg);
        n2 = (hidden2_reg == 7'd0) ? CW'(1) :
             (32'(hidden2_reg) > MAX_HIDDEN) ? CW'(MAX_HIDDEN) : CW'(hidden2_reg);
        no = (out_dim_reg == 5'd0) ? CW'(1) :
             (32'(out_dim_reg) > MAX_OUTPUTS) ? CW'(MAX_OUTPUTS) : CW'(out_dim_reg);
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    logic s_xfer, param_xfer, feat_xfer, feat_final;
    assign s_xfer     = s_valid && s_ready;
    assign param_xfer = s_xfer && (s_req_type == REQ_PARAM);
    assign feat_xfer  = s_xfer && (s_req_type == REQ_FEATURE);
    assign feat_final = (32'(count_reg) + 1 >= 32'(ni));

    // Issue stage: a layer-3 neuron starts only when the output slot is free.
    logic          issue_stall, issue_go, pipe_busy;
    logic [SPW-1:0] p_addr;
    assign issue_stall = (layer_reg == LAYER_3) && (e_reg == '0) && m_valid_reg;
    assign issue_go    = (state_reg == ST_ISSUE) && !issue_stall;
    assign pipe_busy   = f1_reg.valid || f2_reg.valid || done_reg;
    assign p_addr      = (e_reg == '0) ? bias_ptr_reg : w_ptr_reg;

    always_comb begin
        f0.valid = issue_go;
        f0.first = (e_reg == '0);
        f0.last  = (e_reg == nsrc_reg);
        f0.bias  = (e_reg == '0);
        f0.oob   = (32'(p_addr) >= PARAM_DEPTH);
    end

    // Parameter memory: written by requests, read by the MAC sequencer.
    logic        pm_we;
    logic [15:0] pm_rdata;
    assign pm_we = param_xfer && (32'(s_param_index) < PARAM_DEPTH);

    mlp3_ram #(.WIDTH(16), .DEPTH(PARAM_DEPTH)) u_param_ram (
        .aclk    (aclk),
        .we      (pm_we),
        .waddr   (RAW'(s_param_index)),
        .wdata   (s_value),
        .raddr   (RAW'(p_addr)),
        .rd_data (pm_rdata)
    );

    // Activation memory: features, then layer 1, then layer 2 activations.
    logic               res_valid;
    logic signed [15:0] res_raw, res_relu;
    logic               am_we;
    logic [AAW-1:0]     am_waddr, am_raddr;
    logic [15:0]        am_wdata, am_rdata;

    assign res_valid = done_reg;
    assign res_raw   = round_sat(acc_reg);
    assign res_relu  = res_raw[15] ? 16'sd0 : res_raw;

    always_comb begin
        am_we    = 1'b0;
        am_waddr = AAW'(count_reg);
        am_wdata = s_value;
        if (feat_xfer) begin
            am_we = 1'b1;
        end else if (res_valid && (layer_reg == LAYER_1)) begin
            am_we    = 1'b1;
            am_waddr = AAW'(MAX_INPUTS) + AAW'(rj_reg);
            am_wdata = res_relu;
        end else if (res_valid && (layer_reg == LAYER_2)) begin
            am_we    = 1'b1;
            am_waddr = AAW'(MAX_INPUTS + MAX_HIDDEN) + AAW'(rj_reg);
            am_wdata = res_relu;
        end
    end

    assign am_raddr = src_base_reg + AAW'(e_reg - CW'(1));

    mlp3_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
        .aclk    (aclk),
        .we      (am_we),
        .waddr   (am_waddr),
        .wdata   (am_wdata),
        .raddr   (am_raddr),
        .rd_data (am_rdata)
    );

    // Multiply and accumulate stages.
    logic signed [15:0] mul_w, mul_a;
    assign mul_w = f1_reg.oob ? 16'sd0 : $signed(pm_rdata);
    assign mul_a = f1_reg.bias ? Q_ONE : $signed(am_rdata);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_w * mul_a;
        if (f2_reg.valid) begin
            if (f2_reg.first) begin
                acc_reg <= 48'(prod_reg);
            end else begin
                acc_reg <= acc_reg + 48'(prod_reg);
            end
        end
        if (!aresetn) begin
            f1_reg   <= '0;
            f2_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            f1_reg   <= f0;
            f2_reg   <= f1_reg;
            done_reg <= f2_reg.valid && f2_reg.last;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_dim_reg  <= 7'd64;
            hidden1_reg <= 7'd64;
            hidden2_reg <= 7'd64;
            out_dim_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IN_DIM:  in_dim_reg  <= cfg_data;
                CFG_HIDDEN1: hidden1_reg <= cfg_data;
                CFG_HIDDEN2: hidden2_reg <= cfg_data;
                CFG_OUT_DIM: out_dim_reg <= cfg_data[4:0];
                default:     in_dim_reg  <= in_dim_reg;
            endcase
        end
    end

    // Sequencer: layout offsets, layer loading, MAC issue and drain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            layer_reg <= LAYER_1;
            count_reg <= '0;
            e_reg     <= '0;
            j_reg     <= '0;
            rj_reg    <= '0;
        end else begin
            if (res_valid) begin
                rj_reg <= rj_reg + CW'(1);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (feat_xfer) begin
                        if (feat_final) begin
                            count_reg <= '0;
                            state_reg <= ST_SETUP1;
                        end else begin
                            count_reg <= count_reg + FCW'(1);
                        end
                    end
                end
                ST_SETUP1: begin
                    p1_reg    <= SPW'(n1) * SPW'(ni);
                    p2_reg    <= SPW'(n2) * SPW'(n1);
                    p3_reg    <= SPW'(no) * SPW'(n2);
                    state_reg <= ST_SETUP2;
                end
                ST_SETUP2: begin
                    ob1_reg   <= p1_reg;
                    ow2_reg   <= p1_reg + SPW'(n1);
                    ob2_reg   <= p1_reg + SPW'(n1) + p2_reg;
                    ow3_reg   <= p1_reg + SPW'(n1) + p2_reg + SPW'(n2);
                    ob3_reg   <= p1_reg + SPW'(n1) + p2_reg + SPW'(n2) + p3_reg;
                    layer_reg <= LAYER_1;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    e_reg  <= '0;
                    j_reg  <= '0;
                    rj_reg <= '0;
                    unique case (layer_reg)
                        LAYER_1: begin
                            w_ptr_reg    <= '0;
                            bias_ptr_reg <= ob1_reg;
                            nsrc_reg     <= ni;
                            ndst_reg     <= n1;
                            src_base_reg <= '0;
                        end
                        LAYER_2: begin
                            w_ptr_reg    <= ow2_reg;
                            bias_ptr_reg <= ob2_reg;
                            nsrc_reg     <= n1;
                            ndst_reg     <= n2;
                            src_base_reg <= AAW'(MAX_INPUTS);
                        end
                        default: begin
                            w_ptr_reg    <= ow3_reg;
                            bias_ptr_reg <= ob3_reg;
                            nsrc_reg     <= n2;
                            ndst_reg     <= no;
                            src_base_reg <= AAW'(MAX_INPUTS + MAX_HIDDEN);
                        end
                    endcase
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (issue_go) begin
                        if (e_reg != '0) begin
                            w_ptr_reg <= w_ptr_reg + SPW'(1);
                        end
                        if (e_reg == nsrc_reg) begin
                            e_reg        <= '0;
                            j_reg        <= j_reg + CW'(1);
                            bias_ptr_reg <= bias_ptr_reg + SPW'(1);
                            if ((layer_reg == LAYER_3) || (j_reg + CW'(1) == ndst_reg)) begin
                                state_reg <= ST_DRAIN;
                            end
                        end else begin
                            e_reg <= e_reg + CW'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        priority if (layer_reg == LAYER_1) begin
                            layer_reg <= LAYER_2;
                            state_reg <= ST_LOAD;
                        end else if (layer_reg == LAYER_2) begin
                            layer_reg <= LAYER_3;
                            state_reg <= ST_LOAD;
                        end else if (j_reg == ndst_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: loaded by a layer-3 result, freed by a transfer.
    logic res_out;
    assign res_out = res_valid && (layer_reg == LAYER_3);

    always_ff @(posedge aclk) begin
        if (res_out) begin
            m_out_value_reg <= res_raw;
            m_out_index_reg <= 4'(rj_reg);
            m_last_reg      <= (rj_reg + CW'(1) == ndst_reg);
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = m_out_value_reg;
    assign m_out_index = m_out_index_reg;
    assign m_last      = m_last_reg;

    // Checks on sequencing and the output slot.
    `CHK_IMPLY(a_idle_pipe_empty, s_ready, !pipe_busy)
    `CHK_IMPLY(a_no_output_overwrite, res_out, !m_valid_reg)
    `CHK_NEXT(a_result_not_in_idle, f2_reg.valid && f2_reg.last, state_reg != ST_IDLE)
endmodule

### tb/sv/tb_mlp_three_layer_inference_unit.sv
// Self-checking testbench for the three-layer perceptron inference unit.
module tb_mlp_three_layer_inference_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mlp3_pkg::*;

    localparam int STORE_DEPTH    = 16384;
    localparam int IN_MAX         = 64;
    localparam int HID_MAX        = 64;
    localparam int OUT_MAX        = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;

    // Ways of filling the parameter store.
    typedef enum int {FILL_SMALL, FILL_FULL, FILL_MAX, FILL_MIN} fill_mode_t;

    typedef struct {
        logic signed [15:0] value;
        logic [3:0]         index;
        logic               last;
    } net_out_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_req_type = REQ_PARAM;
    logic [13:0]        s_param_index = '0;
    logic signed [15:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_out_value;
    logic [3:0]         m_out_index;
    logic               m_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_IN_DIM;
    logic [6:0]         cfg_data = '0;

    mlp_three_layer_inference_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_param_index(s_param_index), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_value(m_out_value),
        .m_out_index(m_out_index), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: parameter words, activations and the size registers.
    logic signed [15:0] param_mem [STORE_DEPTH];
    logic signed [15:0] feat_vec [IN_MAX];
    logic signed [15:0] act1 [HID_MAX];
    logic signed [15:0] act2 [HID_MAX];
    logic [6:0]         size_reg [4];
    int                 feat_cnt;
    net_out_t           expected_outs [$];

    int  errors = 0;
    int  items_sent = 0;
    int  vectors_run = 0;
    int  results_seen = 0;
    bit  pace_on = 1'b0;
    int  burst_left = 1;
    bit  long_hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_mode = 0;
    int  phase_left = 0;
    int  idle_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_size(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int n_in();
        return clamp_size(size_reg[CFG_IN_DIM], IN_MAX);
    endfunction
    function automatic int n_h1();
        return clamp_size(size_reg[CFG_HIDDEN1], HID_MAX);
    endfunction
    function automatic int n_h2();
        return clamp_size(size_reg[CFG_HIDDEN2], HID_MAX);
    endfunction
    function automatic int n_out();
        return clamp_size(size_reg[CFG_OUT_DIM], OUT_MAX);
    endfunction

    // Number of store words that the current sizes reference.
    function automatic int layout_words();
        return n_h1() * (n_in() + 1) + n_h2() * (n_h1() + 1) + n_out() * (n_h2() + 1);
    endfunction

    // Round half up to Q4.12 and clip to 16 bits.
    function automatic logic signed [15:0] to_q412(logic signed [47:0] acc);
        logic signed [47:0] r;
        r = (acc + 48'sd2048) >>> 12;
        if (r > 48'sd32767) return 16'sh7FFF;
        if (r < -48'sd32768) return 16'sh8000;
        return r[15:0];
    endfunction

    // One neuron: bias plus weight row times source activations.
    function automatic logic signed [15:0] neuron_sum(int wbase, int baddr,
                                                      logic signed [15:0] src [64], int n);
        logic signed [47:0] acc;
        acc = param_mem[baddr];
        acc = acc <<< 12;
        for (int i = 0; i < n; i++) begin
            acc = acc + param_mem[wbase + i] * src[i];
        end
        return to_q412(acc);
    endfunction

    // Evaluate the whole network and queue the outputs it produces.
    task automatic evaluate_network();
        int ni, n1, n2, no, ob1, ow2, ob2, ow3, ob3;
        logic signed [15:0] s;
        net_out_t o;
        ni = n_in(); n1 = n_h1(); n2 = n_h2(); no = n_out();
        ob1 = n1 * ni;
        ow2 = ob1 + n1;
        ob2 = ow2 + n2 * n1;
        ow3 = ob2 + n2;
        ob3 = ow3 + no * n2;
        for (int j = 0; j < n1; j++) begin
            s = neuron_sum(j * ni, ob1 + j, feat_vec, ni);
            act1[j] = (s < 0) ? 16'sd0 : s;
        end
        for (int j = 0; j < n2; j++) begin
            s = neuron_sum(ow2 + j * n1, ob2 + j, act1, n1);
            act2[j] = (s < 0) ? 16'sd0 : s;
        end
        for (int j = 0; j < no; j++) begin
            o.value = neuron_sum(ow3 + j * n2, ob3 + j, act2, n2);
            o.index = j[3:0];
            o.last  = (j + 1 == no);
            expected_outs.push_back(o);
        end
        vectors_run++;
    endtask

    // Apply one accepted request to the predictor.
    task automatic apply_request(logic rtype, logic [13:0] idx, logic signed [15:0] val);
        if (rtype == REQ_PARAM) begin
            param_mem[idx] = val;
        end else begin
            if (feat_cnt < IN_MAX) feat_vec[feat_cnt] = val;
            feat_cnt++;
            if (feat_cnt >= n_in()) begin
                feat_cnt = 0;
                evaluate_network();
            end
        end
    endtask

    function automatic logic signed [15:0] gen_value(fill_mode_t mode);
        case (mode)
            FILL_SMALL: return 16'($urandom_range(0, 4095)) - 16'sd2048;
            FILL_FULL:  return 16'($urandom);
            FILL_MAX:   return 16'sh7FFF;
            default:    return 16'sh8000;
        endcase
    endfunction

    // Offer one request and wait for its transfer; bursts and gaps when pacing.
    task automatic send_request(logic rtype, logic [13:0] idx, logic signed [15:0] val);
        s_valid       <= 1'b1;
        s_req_type    <= rtype;
        s_param_index <= idx;
        s_value       <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(rtype, idx, val);
        items_sent++;
        if (pace_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Stop offering and wait until every queued output has come back.
    task automatic drain_outputs();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_outs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Write all four size registers back to back while the unit is idle.
    task automatic program_sizes(int a, int b, int c, int d);
        logic [1:0] idx_list [4];
        int         vals [4];
        idx_list = '{CFG_IN_DIM, CFG_HIDDEN1, CFG_HIDDEN2, CFG_OUT_DIM};
        vals = '{a, b, c, d};
        drain_outputs();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= 7'(vals[i]);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            size_reg[idx_list[i]] = (idx_list[i] == CFG_OUT_DIM) ? 7'(vals[i] & 31)
                                                                  : 7'(vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Write every word of the current layout.
    task automatic load_network(fill_mode_t mode);
        int words;
        words = layout_words();
        for (int a = 0; a < words; a++) begin
            send_request(REQ_PARAM, 14'(a), gen_value(mode));
        end
    endtask

    // Send the features that complete the current vector.
    task automatic send_vector(fill_mode_t mode);
        int n;
        n = n_in() - feat_cnt;
        for (int i = 0; i < n; i++) send_request(REQ_FEATURE, 14'($urandom), gen_value(mode));
    endtask

    // All sizes zero act as one; also the top store address at both extremes.
    task automatic test_minimum_sizes();
        pace_on = 1'b0;
        program_sizes(0, 0, 0, 0);
        load_network(FILL_SMALL);
        send_request(REQ_PARAM, 14'h3FFF, 16'sh7FFF);
        send_request(REQ_PARAM, 14'h3FFF, 16'sh8000);
        send_vector(FILL_FULL);
        send_vector(FILL_SMALL);
    endtask

    // Parameters and features at the extremes drive saturation both ways.
    task automatic test_saturation();
        program_sizes(4, 3, 2, 5);
        load_network(FILL_MAX);
        send_vector(FILL_MAX);
        send_vector(FILL_MIN);
        load_network(FILL_MIN);
        send_vector(FILL_MAX);
        send_vector(FILL_MIN);
        send_request(REQ_FEATURE, 14'h0000, 16'sh0000);
        send_vector(FILL_FULL);
    endtask

    // Register values above their maximum act as the maximum.
    task automatic test_oversize();
        pace_on = 1'b1;
        program_sizes(127, 1, 1, 31);
        load_network(FILL_SMALL);
        send_vector(FILL_SMALL);
    endtask

    // Lowering in_dim with a partly filled vector fires on the next feature.
    task automatic test_shrink_midvector();
        program_sizes(8, 2, 2, 3);
        load_network(FILL_SMALL);
        for (int i = 0; i < 5; i++) send_request(REQ_FEATURE, 14'($urandom), gen_value(FILL_FULL));
        program_sizes(3, 2, 2, 3);
        load_network(FILL_FULL);
        send_request(REQ_FEATURE, 14'($urandom), gen_value(FILL_FULL));
        send_vector(FILL_SMALL);
    endtask

    // Receiver holds off long while features keep coming, then a full drain.
    task automatic test_backpressure();
        pace_on = 1'b0;
        program_sizes(2, 2, 2, 16);
        load_network(FILL_SMALL);
        long_hold_req = 1'b1;
        for (int v = 0; v < 6; v++) send_vector(FILL_SMALL);
        drain_outputs();
    endtask

    // Random sizes and weights, mostly features with scattered parameter writes.
    task automatic test_random_traffic();
        fill_mode_t mode;
        int         words;
        for (int ph = 0; ph < 2; ph++) begin
            pace_on = $urandom_range(0, 1);
            program_sizes($urandom_range(1, 2), $urandom_range(1, 2),
                          $urandom_range(1, 2), $urandom_range(1, 6));
            mode = ($urandom_range(0, 3) == 0) ? FILL_FULL : FILL_SMALL;
            load_network(mode);
            words = layout_words();
            for (int i = 0; i < 6; i++) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_request(REQ_FEATURE, 14'($urandom), gen_value(mode));
                end else if ($urandom_range(0, 1) == 0) begin
                    send_request(REQ_PARAM, 14'($urandom_range(0, words - 1)), gen_value(mode));
                end else begin
                    send_request(REQ_PARAM, 14'($urandom), gen_value(FILL_FULL));
                end
            end
        end
    endtask

    // Main sequence.
    initial begin
        size_reg = '{7'd64, 7'd64, 7'd64, 7'd16};
        feat_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_minimum_sizes();
        test_saturation();
        test_oversize();
        test_shrink_midvector();
        test_backpressure();
        test_random_traffic();
        drain_outputs();
        repeat (50) @(posedge aclk);
        $display("Sent %0d requests, ran %0d vectors, checked %0d outputs, %0d errors.",
                 items_sent, vectors_run, results_seen, errors);
        $display("Covered minimum, oversize and random sizes, saturation and backpressure.");
        if (errors == 0) begin
            $display("mlp_three_layer_inference_unit regression: pass");
        end else begin
            $display("mlp_three_layer_inference_unit regression: fail");
        end
        $finish;
    end

    // Output side: random stall patterns plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each output transfer with the oldest expected output.
    always @(posedge aclk) begin
        net_out_t exp_o;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_outs.size() == 0) begin
                $display("%0t: unexpected output value %0d index %0d last %0b",
                         $time, m_out_value, m_out_index, m_last);
                errors++;
            end else begin
                exp_o = expected_outs.pop_front();
                if (m_out_value !== exp_o.value) begin
                    $display("%0t: out_value expected %0d actual %0d",
                             $time, exp_o.value, m_out_value);
                    errors++;
                end
                if (m_out_index !== exp_o.index) begin
                    $display("%0t: out_index expected %0d actual %0d",
                             $time, exp_o.index, m_out_index);
                    errors++;
                end
                if (m_last !== exp_o.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, exp_o.last, m_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d outputs outstanding",
                         $time, idle_cycles, expected_outs.size());
                $display("mlp_three_layer_inference_unit regression: fail");
                $finish;
            end
        end
    end

endmodule
